>>> hw/rtl/ubd_pkg.sv
// Shared types and constants for the UART baud divisor calculator.
// No dependencies.
package ubd_pkg;

  localparam int unsigned ClkW  = 31;
  localparam int unsigned TolW  = 10;
  localparam int unsigned BaudW = 24;
  localparam int unsigned DivW  = 16;
  localparam int unsigned AddrW = 2;

  localparam logic [ClkW-1:0] ClkReset = 31'd1843200;
  localparam logic [TolW-1:0] TolReset = 10'd30;
  localparam logic [10:0]     ErrScale = 11'd2000;

  typedef enum logic [AddrW-1:0] {
    REG_REF_CLOCK = 2'd0,
    REG_TOLERANCE = 2'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAUD_ZERO = 2'd1,
    ST_DIV_RANGE = 2'd2,
    ST_TOLERANCE = 2'd3
  } status_e;

endpackage

>>> hw/rtl/uart_baud_divisor_calc.sv
// UART 16x baud divisor calculator with tolerance check (top level).
// Throughput: one request per cycle; busy is always low. The three pipelined
// dividers (28, 27 and 38 stages) plus three arithmetic stages set the latency.
// Reset clears all valid bits and loads clock 1843200 Hz and tolerance 30.
// Uses ubd_pkg and ubd_pipe_div.
module uart_baud_divisor_calc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ubd_pkg::BaudW-1:0]  baud_rate_i,
  input  logic                       cfg_we_i,
  input  logic [ubd_pkg::AddrW-1:0]  cfg_addr_i,
  input  logic [ubd_pkg::ClkW-1:0]   cfg_wdata_i,
  output logic                       result_valid_o,
  output logic [ubd_pkg::DivW-1:0]   divisor_o,
  output logic [1:0]                 status_o
);

  localparam int unsigned Div1W = 28;
  localparam int unsigned Div2W = 27;
  localparam int unsigned Div3W = 38;
  localparam int unsigned Latency = Div1W + Div2W + Div3W + 3;
  localparam int unsigned Tag2W = ubd_pkg::BaudW + ubd_pkg::DivW + 2;
  localparam int unsigned Tag3W = ubd_pkg::DivW + 3;

  logic [ubd_pkg::ClkW-1:0] clk_hz_q;
  logic [ubd_pkg::TolW-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ubd_pkg::ClkReset;
      tol_q    <= ubd_pkg::TolReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ubd_pkg::REG_REF_CLOCK: clk_hz_q <= cfg_wdata_i;
        ubd_pkg::REG_TOLERANCE: tol_q    <= cfg_wdata_i[ubd_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  // Divider 1: floor(clk / (8 * baud)) == floor(floor(clk / 8) / baud).
  logic                      d1_vld;
  logic [Div1W-1:0]          d1_quot;
  logic [ubd_pkg::BaudW-1:0] d1_baud;

  ubd_pipe_div #(.NUM_W(Div1W), .DEN_W(ubd_pkg::BaudW), .TAG_W(ubd_pkg::BaudW)) u_div1 (
    .clk_i, .rst_ni,
    .in_valid_i (accept),
    .num_i      (clk_hz_q[ubd_pkg::ClkW-1:3]),
    .den_i      (baud_rate_i),
    .tag_i      (baud_rate_i),
    .out_valid_o(d1_vld),
    .quot_o     (d1_quot),
    .tag_o      (d1_baud)
  );

  // Stage B: round the divisor, flag a zero baud rate and check the divisor's range.
  logic [Div1W:0]            div_sum;
  logic [Div1W-1:0]          div_full;
  logic                      b_vld_q;
  logic [ubd_pkg::BaudW-1:0] b_baud_q;
  logic [ubd_pkg::DivW-1:0]  b_div_q;
  ubd_pkg::status_e          b_st_d, b_st_q;

  assign div_sum  = {1'b0, d1_quot} + {{Div1W{1'b0}}, 1'b1};
  assign div_full = div_sum[Div1W:1];

  always_comb begin
    if (d1_baud == '0) begin
      b_st_d = ubd_pkg::ST_BAUD_ZERO;
    end else if (div_full == '0 || div_full[Div1W-1:ubd_pkg::DivW] != '0) begin
      b_st_d = ubd_pkg::ST_DIV_RANGE;
    end else begin
      b_st_d = ubd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    b_baud_q <= d1_baud;
    b_div_q  <= div_full[ubd_pkg::DivW-1:0];
    b_st_q   <= b_st_d;
  end

  // Divider 2: actual = floor(clk / (16 * div)) == floor(floor(clk / 16) / div).
  logic                      d2_vld;
  logic [Div2W-1:0]          d2_actual;
  logic [Tag2W-1:0]          d2_tag;
  logic [ubd_pkg::BaudW-1:0] d2_baud;
  logic [ubd_pkg::DivW-1:0]  d2_div;
  logic [1:0]                d2_st;

  ubd_pipe_div #(.NUM_W(Div2W), .DEN_W(ubd_pkg::DivW), .TAG_W(Tag2W)) u_div2 (
    .clk_i, .rst_ni,
    .in_valid_i (b_vld_q),
    .num_i      (clk_hz_q[ubd_pkg::ClkW-1:4]),
    .den_i      (b_div_q),
    .tag_i      ({b_baud_q, b_div_q, b_st_q}),
    .out_valid_o(d2_vld),
    .quot_o     (d2_actual),
    .tag_o      (d2_tag)
  );

  assign {d2_baud, d2_div, d2_st} = d2_tag;

  // Stage C: magnitude of (actual - baud) scaled by 2000.
  logic signed [Div2W:0]     diff;
  logic [Div2W:0]            diff_mag;
  logic                      c_vld_q;
  logic [Div3W-1:0]          c_prod_q;
  logic                      c_neg_q;
  logic [ubd_pkg::BaudW-1:0] c_baud_q;
  logic [ubd_pkg::DivW-1:0]  c_div_q;
  logic [1:0]                c_st_q;

  assign diff     = signed'({1'b0, d2_actual}) - signed'({4'b0, d2_baud});
  assign diff_mag = diff[Div2W] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    c_prod_q <= Div3W'({{(Div3W-Div2W-1){1'b0}}, diff_mag} * {{(Div3W-11){1'b0}},
                                                               ubd_pkg::ErrScale});
    c_neg_q  <= diff[Div2W];
    c_baud_q <= d2_baud;
    c_div_q  <= d2_div;
    c_st_q   <= d2_st;
  end

  // Divider 3: |error| * 2000 / baud, sign restored afterward (truncation to zero).
  logic                     d3_vld;
  logic [Div3W-1:0]         d3_quot;
  logic [Tag3W-1:0]         d3_tag;
  logic                     d3_neg;
  logic [ubd_pkg::DivW-1:0] d3_div;
  logic [1:0]               d3_st;

  ubd_pipe_div #(.NUM_W(Div3W), .DEN_W(ubd_pkg::BaudW), .TAG_W(Tag3W)) u_div3 (
    .clk_i, .rst_ni,
    .in_valid_i (c_vld_q),
    .num_i      (c_prod_q),
    .den_i      (c_baud_q),
    .tag_i      ({c_neg_q, c_div_q, c_st_q}),
    .out_valid_o(d3_vld),
    .quot_o     (d3_quot),
    .tag_o      (d3_tag)
  );

  assign {d3_neg, d3_div, d3_st} = d3_tag;

  // Stage D: halve with rounding (floor of (err + 1) / 2) and compare against the tolerance.
  logic signed [Div3W+1:0] err;
  logic signed [Div3W+1:0] err_half;
  logic signed [Div3W+1:0] tol_s;
  logic [1:0]              st_d;

  assign err      = d3_neg ? -signed'({2'b0, d3_quot}) : signed'({2'b0, d3_quot});
  assign err_half = (err + 40'sd1) >>> 1;
  assign tol_s    = signed'({{(Div3W+2-ubd_pkg::TolW){1'b0}}, tol_q});

  always_comb begin
    st_d = d3_st;
    if (d3_st == ubd_pkg::ST_OK && (err_half < -tol_s || err_half > tol_s)) begin
      st_d = ubd_pkg::ST_TOLERANCE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= d3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    status_o  <= st_d;
    divisor_o <= (st_d == ubd_pkg::ST_OK) ? d3_div : '0;
  end

  // Every request gives exactly one result after the fixed pipeline depth.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency result_valid_o)
    else $error("result missing after a request");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, Latency))
    else $error("result without a request");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ubd_pkg::ST_OK |-> divisor_o == '0)
    else $error("rejected request with nonzero divisor");

  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ubd_pkg::ST_OK |-> divisor_o != '0)
    else $error("accepted request with zero divisor");

endmodule

>>> hw/rtl/ubd_pipe_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// A side tag travels with each operand pair. Depends on nothing.
module ubd_pipe_div #(
  parameter int unsigned NUM_W = 28,
  parameter int unsigned DEN_W = 24,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             out_valid_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [TAG_W-1:0] tag_o
);

  // The numerator register shifts left; quotient bits enter at the bottom,
  // so after NUM_W stages it holds the quotient.
  logic             vld_q [NUM_W];
  logic [NUM_W-1:0] num_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [TAG_W-1:0] tag_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             vld_in;
    logic [NUM_W-1:0] num_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in = in_valid_i;
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign rem_in = rem_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k] <= {num_in[NUM_W-2:0], ge};
      den_q[k] <= den_in;
      rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      tag_q[k] <= tag_in;
    end
  end

  assign out_valid_o = vld_q[NUM_W-1];
  assign quot_o      = num_q[NUM_W-1];
  assign tag_o       = tag_q[NUM_W-1];

endmodule
